[rtl/ablc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ambient light backlight control package
// Shared types, fixed-point constants and the log2 fraction table generator.
// ----------------------------------------------------------------------------
package ablc_pkg;

    // Parameter defaults
    localparam int unsigned LOG_TABLE_DEPTH_DEF = 64;
    localparam int unsigned LEVEL_BITS_DEF      = 16;

    // Shared multiplier geometry (signed operands, registered product)
    localparam int unsigned MUL_W  = 30;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // Datapath widths
    localparam int unsigned FRAC_W = 19;   // signed Q.16 fraction
    localparam int unsigned LOG_W  = 22;   // signed Q.16 log2 of lux
    localparam int unsigned LUX_W  = 34;   // signed Q.8 lux

    // Fixed-point constants
    localparam int unsigned ONE_Q16    = 65536;
    localparam int unsigned CURVE_GAIN = 1155035;  // 9.9323 * ln 2 / 100, Q.24
    localparam int unsigned CURVE_BIAS = 4539747;  // 0.27059, Q.24
    localparam int unsigned CURVE_SHIFT = 24;
    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^30
    localparam int unsigned DIV10_MUL   = 214748365;
    localparam int unsigned DIV10_SHIFT = 31;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SENSOR_SCALE     = 3'd0,
        REG_SENSOR_OFFSET    = 3'd1,
        REG_MAX_LUX          = 3'd2,
        REG_BACKLIGHT_LIMITS = 3'd3,
        REG_BACKLIGHT_SCALE  = 3'd4,
        REG_KEYBOARD_LIMITS  = 3'd5,
        REG_KEYBOARD_SCALE   = 3'd6,
        REG_OUTPUT_ENABLES   = 3'd7
    } ablc_reg_t;

    localparam int unsigned CFG_DATA_W = 34;

    typedef struct packed {
        logic [15:0]        sensor_scale;
        logic signed [23:0] sensor_offset;
        logic [31:0]        max_lux;
        logic [33:0]        backlight_limits;
        logic [15:0]        backlight_scale;
        logic [33:0]        keyboard_limits;
        logic [15:0]        keyboard_scale;
        logic [1:0]         output_enables;
    } ablc_cfg_t;

    typedef struct packed {
        logic [16:0] light_fraction;
        logic [15:0] backlight_level;
        logic        backlight_write;
        logic [15:0] keyboard_level;
        logic        keyboard_write;
    } ablc_result_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_LUX,
        ST_ADD_LUX,
        ST_NORM,
        ST_TAB0,
        ST_TAB1,
        ST_TAB2,
        ST_MUL_INTERP,
        ST_SUM_LOG,
        ST_MUL_CURVE,
        ST_FRAC,
        ST_MUL_BL,
        ST_BL_SUM,
        ST_MUL_DIV,
        ST_BL_UPD,
        ST_MUL_KB,
        ST_KB_UPD,
        ST_DONE
    } ablc_state_t;

    // Entry i of the log2(1 + i/depth) table in Q.16, evaluated at elaboration.
    // Seed is floor(((depth + i) << 30) / depth) by restoring long division,
    // then sixteen square-and-compare steps give the fraction bits MSB first.
    function automatic logic [15:0] ablc_log_entry(input int unsigned i,
                                                   input int unsigned depth);
        logic [40:0] num;
        logic [40:0] quo;
        logic [41:0] part;
        logic [63:0] x;
        logic [15:0] bits;
        num  = 41'(longint'(depth + i)) << 30;
        quo  = '0;
        part = '0;
        for (int b = 40; b >= 0; b--) begin
            part = {part[40:0], num[b]};
            if (part >= 42'(depth)) begin
                part   = part - 42'(depth);
                quo[b] = 1'b1;
            end
        end
        x    = 64'(quo);
        bits = '0;
        for (int k = 0; k < 16; k++) begin
            x    = (x * x) >> 30;
            bits = {bits[14:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                x       = x >> 1;
                bits[0] = 1'b1;
            end
        end
        return bits;
    endfunction

endpackage : ablc_pkg
`default_nettype wire

[rtl/ablc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused by each multiplying
// step of the sequencer.
// ----------------------------------------------------------------------------
module ablc_mul (
    input  wire logic                              aclk,
    input  wire logic signed [ablc_pkg::MUL_W-1:0]  mul_a,
    input  wire logic signed [ablc_pkg::MUL_W-1:0]  mul_b,
    output logic signed [ablc_pkg::PROD_W-1:0]      prod_reg
);
    import ablc_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    // Form the full-width product
    always_comb begin
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Register the product for the following step
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule : ablc_mul
`default_nettype wire

[rtl/ablc_log_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Log2 fraction table
// Constant table of log2(1 + i/depth) in Q.16 with a registered read port.
// ----------------------------------------------------------------------------
module ablc_log_rom #(
    parameter int unsigned LOG_TABLE_DEPTH = ablc_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic [$clog2(LOG_TABLE_DEPTH)-1:0] rom_addr,
    output logic [15:0]                             rom_q_reg
);
    import ablc_pkg::*;

    logic [15:0] rom_w [LOG_TABLE_DEPTH];

    // Fill the table with elaboration-time constants
    for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_entry
        assign rom_w[g] = ablc_log_entry(g, LOG_TABLE_DEPTH);
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rom_q_reg <= rom_w[rom_addr];
    end

endmodule : ablc_log_rom
`default_nettype wire

[rtl/ablc_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample sequencer
// Steps one sample through lux scaling, normalisation, table log2, curve,
// limit clamping, level scaling and backlight smoothing, using the shared multiplier.
// ----------------------------------------------------------------------------
module ablc_seq #(
    parameter int unsigned LOG_TABLE_DEPTH = ablc_pkg::LOG_TABLE_DEPTH_DEF,
    parameter int unsigned LEVEL_BITS      = ablc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ablc_pkg::ablc_cfg_t                cfg,
    // sample input
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [15:0]                        in_raw,
    // result towards the output register
    output logic                                    res_valid,
    output ablc_pkg::ablc_result_t                  res,
    input  wire logic                               res_free,
    // shared multiplier
    output logic signed [ablc_pkg::MUL_W-1:0]       mul_a,
    output logic signed [ablc_pkg::MUL_W-1:0]       mul_b,
    input  wire logic signed [ablc_pkg::PROD_W-1:0] prod,
    // log table
    output logic [$clog2(LOG_TABLE_DEPTH)-1:0]      rom_addr,
    input  wire logic [15:0]                        rom_q
);
    import ablc_pkg::*;

    localparam int unsigned IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int unsigned POS_W = 16 + IDX_W;
    localparam int unsigned SUM_W = LEVEL_BITS + 4;
    localparam logic [31:0] LEVEL_MAX32 = 32'((64'd1 << LEVEL_BITS) - 64'd1);

    ablc_state_t state_reg, state_next;

    logic [15:0]                raw_reg;
    logic [31:0]                norm_reg;
    logic [4:0]                 p_reg;
    logic [15:0]                t0_reg;
    logic [16:0]                t1_reg;
    logic signed [LOG_W-1:0]    log_reg;
    logic signed [FRAC_W-1:0]   frac_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [LEVEL_BITS-1:0]      bl_now_reg;
    logic [LEVEL_BITS-1:0]      kb_now_reg;
    logic                       bl_write_reg;
    logic                       kb_write_reg;

    logic [POS_W-1:0]           pos;
    logic [IDX_W-1:0]           idx;
    logic [15:0]                rem;
    logic                       idx_last;
    logic signed [LUX_W-1:0]    lux;
    logic                       lux_over;
    logic                       lux_nonpos;
    logic [16:0]                diff;
    logic [15:0]                interp;
    logic [5:0]                 p_off;
    logic [PROD_W-1:0]          curve;
    logic signed [FRAC_W-1:0]   kb_frac;
    logic [16:0]                bl_clamped;
    logic [16:0]                kb_clamped;
    logic [LEVEL_BITS-1:0]      target;
    logic [LEVEL_BITS-1:0]      bl_next;
    logic [SUM_W-1:0]           sum_next;

    // Clamp a signed fraction to [min, max]; with crossed limits, below min gives min, else max
    function automatic logic [16:0] clamp_lim(input logic signed [FRAC_W-1:0] v,
                                              input logic [33:0] lim);
        logic signed [FRAC_W-1:0] lo;
        logic signed [FRAC_W-1:0] hi;
        logic [16:0]              r;
        lo = $signed({2'b00, lim[16:0]});
        hi = $signed({2'b00, lim[33:17]});
        if (v < lo) begin
            r = lim[16:0];
        end else if (v > hi) begin
            r = lim[33:17];
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    // Table index and interpolation weight from the bits under the leading one
    always_comb begin
        pos      = POS_W'(norm_reg[30:15]) * POS_W'(LOG_TABLE_DEPTH);
        idx      = pos[POS_W-1:16];
        rem      = pos[15:0];
        idx_last = (idx == IDX_W'(LOG_TABLE_DEPTH - 1));
    end

    // Lux and its range checks
    always_comb begin
        lux        = $signed({2'b00, prod[31:0]})
                   + $signed({{(LUX_W-24){cfg.sensor_offset[23]}}, cfg.sensor_offset});
        lux_over   = lux > $signed({2'b00, cfg.max_lux});
        lux_nonpos = lux[LUX_W-1] || (lux == '0);
    end

    // Interpolation, log assembly and curve
    always_comb begin
        diff    = (t1_reg > {1'b0, t0_reg}) ? (t1_reg - {1'b0, t0_reg}) : '0;
        interp  = t0_reg + prod[31:16];
        p_off   = {1'b0, p_reg} - 6'd8;
        curve   = prod + PROD_W'(CURVE_BIAS);
        kb_frac = FRAC_W'(ONE_Q16) - frac_reg;
    end

    // Clamped fractions, scaled target and smoothing
    always_comb begin
        bl_clamped = clamp_lim(frac_reg, cfg.backlight_limits);
        kb_clamped = clamp_lim(kb_frac, cfg.keyboard_limits);
        if ({15'b0, prod[32:16]} > LEVEL_MAX32) begin
            target = LEVEL_MAX32[LEVEL_BITS-1:0];
        end else begin
            target = LEVEL_BITS'(prod[32:16]);
        end
        sum_next = SUM_W'({bl_now_reg, 3'b000}) + SUM_W'(bl_now_reg) + SUM_W'(target);
        bl_next  = prod[DIV10_SHIFT +: LEVEL_BITS];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL_LUX;
            ST_MUL_LUX:    state_next = ST_ADD_LUX;
            ST_ADD_LUX: begin
                if (lux_over || lux_nonpos) begin
                    state_next = ST_MUL_BL;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:       if (norm_reg[31]) state_next = ST_TAB0;
            ST_TAB0:       state_next = ST_TAB1;
            ST_TAB1:       state_next = ST_TAB2;
            ST_TAB2:       state_next = ST_MUL_INTERP;
            ST_MUL_INTERP: state_next = ST_SUM_LOG;
            ST_SUM_LOG:    state_next = ST_MUL_CURVE;
            ST_MUL_CURVE:  state_next = ST_FRAC;
            ST_FRAC:       state_next = ST_MUL_BL;
            ST_MUL_BL:     state_next = ST_BL_SUM;
            ST_BL_SUM:     state_next = ST_MUL_DIV;
            ST_MUL_DIV:    state_next = ST_BL_UPD;
            ST_BL_UPD:     state_next = ST_MUL_KB;
            ST_MUL_KB:     state_next = ST_KB_UPD;
            ST_KB_UPD:     state_next = ST_DONE;
            ST_DONE:       if (res_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, multiplier operands and table address
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        mul_a     = '0;
        mul_b     = '0;
        rom_addr  = idx;
        unique case (state_reg)
            ST_MUL_LUX: begin
                mul_a = MUL_W'(raw_reg);
                mul_b = MUL_W'(cfg.sensor_scale);
            end
            ST_TAB1: begin
                rom_addr = idx_last ? idx : (idx + IDX_W'(1));
            end
            ST_MUL_INTERP: begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(rem);
            end
            ST_MUL_CURVE: begin
                mul_a = MUL_W'(log_reg);
                mul_b = MUL_W'(CURVE_GAIN);
            end
            ST_MUL_BL: begin
                mul_a = MUL_W'(bl_clamped);
                mul_b = MUL_W'(cfg.backlight_scale);
            end
            ST_MUL_DIV: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(DIV10_MUL);
            end
            ST_MUL_KB: begin
                mul_a = MUL_W'(kb_clamped);
                mul_b = MUL_W'(cfg.keyboard_scale);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Result assembly; the fraction saturates to 0..1
    always_comb begin
        if (frac_reg < 0) begin
            res.light_fraction = '0;
        end else if (frac_reg > $signed(FRAC_W'(ONE_Q16))) begin
            res.light_fraction = 17'(ONE_Q16);
        end else begin
            res.light_fraction = frac_reg[16:0];
        end
        res.backlight_level = 16'(bl_now_reg);
        res.backlight_write = bl_write_reg;
        res.keyboard_level  = 16'(kb_now_reg);
        res.keyboard_write  = kb_write_reg;
    end

    // Control state and levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bl_now_reg   <= '0;
            kb_now_reg   <= '0;
            bl_write_reg <= 1'b0;
            kb_write_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_BL_UPD) begin
                bl_write_reg <= cfg.output_enables[0] && (bl_next != bl_now_reg);
                if (cfg.output_enables[0]) begin
                    bl_now_reg <= bl_next;
                end
            end
            if (state_reg == ST_KB_UPD) begin
                kb_write_reg <= cfg.output_enables[1] && (target != kb_now_reg);
                if (cfg.output_enables[1]) begin
                    kb_now_reg <= target;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) raw_reg <= in_raw;
            end
            ST_ADD_LUX: begin
                norm_reg <= lux[31:0];
                p_reg    <= 5'd31;
                if (lux_over) begin
                    frac_reg <= FRAC_W'(ONE_Q16);
                end else if (lux_nonpos) begin
                    frac_reg <= '0;
                end
            end
            ST_NORM: begin
                // shift until the leading one reaches the top bit
                if (!norm_reg[31]) begin
                    norm_reg <= {norm_reg[30:0], 1'b0};
                    p_reg    <= p_reg - 5'd1;
                end
            end
            ST_TAB1: t0_reg <= rom_q;
            ST_TAB2: t1_reg <= idx_last ? 17'(ONE_Q16) : {1'b0, rom_q};
            ST_SUM_LOG: log_reg <= $signed({p_off, interp});
            ST_FRAC: frac_reg <= curve[CURVE_SHIFT +: FRAC_W];
            ST_BL_SUM: sum_reg <= sum_next;
            default: begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule : ablc_seq
`default_nettype wire

[rtl/ambient_light_backlight_control_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A sample whose lux is non-positive or above max_lux skips normalisation, table and
//   curve; else the time to m_tvalid grows as p, the leading-one position of lux, falls.
// The span is set by the one-bit-per-cycle normalising shift and the passes through
//   the single shared multiplier (six on the full path, four when lux is out of range).
// One sample is in work at a time; s_tready rises with m_tvalid, which waits on m_tready.
// Reset (aresetn low, synchronous) clears both levels and loads register defaults.
// ----------------------------------------------------------------------------
// Ambient light backlight control, top level
// Configuration registers, sample sequencer, shared multiplier, log table and
// output register.
// ----------------------------------------------------------------------------
module ambient_light_backlight_control_top #(
    parameter int unsigned LOG_TABLE_DEPTH = ablc_pkg::LOG_TABLE_DEPTH_DEF,
    parameter int unsigned LEVEL_BITS      = ablc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [ablc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sample input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,   // [15:0] raw_sample
    // result output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [16:0] light_fraction, [32:17] backlight_level, [33] backlight_write,
    // [49:34] keyboard_level, [50] keyboard_write, [55:51] zero
    output logic [55:0]                              m_tdata
);
    import ablc_pkg::*;

    ablc_cfg_t                 cfg_reg;
    ablc_result_t              res;
    logic                      res_valid;
    logic                      res_free;
    logic                      m_tvalid_reg;
    logic [55:0]               m_tdata_reg;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [$clog2(LOG_TABLE_DEPTH)-1:0] rom_addr;
    logic [15:0]               rom_q;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_scale     <= 16'd256;
            cfg_reg.sensor_offset    <= '0;
            cfg_reg.max_lux          <= 32'd256000;
            cfg_reg.backlight_limits <= 34'h2_0000_0000;
            cfg_reg.backlight_scale  <= 16'd255;
            cfg_reg.keyboard_limits  <= 34'h2_0000_0000;
            cfg_reg.keyboard_scale   <= 16'd255;
            cfg_reg.output_enables   <= 2'b11;
        end else if (cfg_we) begin
            unique case (ablc_reg_t'(cfg_index))
                REG_SENSOR_SCALE:     cfg_reg.sensor_scale     <= cfg_wdata[15:0];
                REG_SENSOR_OFFSET:    cfg_reg.sensor_offset    <= $signed(cfg_wdata[23:0]);
                REG_MAX_LUX:          cfg_reg.max_lux          <= cfg_wdata[31:0];
                REG_BACKLIGHT_LIMITS: cfg_reg.backlight_limits <= cfg_wdata[33:0];
                REG_BACKLIGHT_SCALE:  cfg_reg.backlight_scale  <= cfg_wdata[15:0];
                REG_KEYBOARD_LIMITS:  cfg_reg.keyboard_limits  <= cfg_wdata[33:0];
                REG_KEYBOARD_SCALE:   cfg_reg.keyboard_scale   <= cfg_wdata[15:0];
                REG_OUTPUT_ENABLES:   cfg_reg.output_enables   <= cfg_wdata[1:0];
                default:              cfg_reg.output_enables   <= cfg_reg.output_enables;
            endcase
        end
    end

    ablc_seq #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH),
        .LEVEL_BITS      (LEVEL_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_raw    (s_tdata),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .prod      (prod),
        .rom_addr  (rom_addr),
        .rom_q     (rom_q)
    );

    ablc_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    ablc_log_rom #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_rom (
        .aclk      (aclk),
        .rom_addr  (rom_addr),
        .rom_q_reg (rom_q)
    );

    // Output register: take a new word when empty or being drained
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Hold the payload until the word is taken
    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_tdata_reg <= {5'b0, res.keyboard_write, res.keyboard_level,
                            res.backlight_write, res.backlight_level,
                            res.light_fraction};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : ambient_light_backlight_control_top
`default_nettype wire
